// ===== rtl/crq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crq_pkg
// shared codes, widths and the step record of the circle quadrant rasterizer
// ----------------------------------------------------------------------------
package crq_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int PIX_W   = 16;   // reported coordinate width
    localparam int WALK_W  = 16;   // walk position width
    localparam int ERR_W   = 18;   // error term width
    localparam int RAD_W   = 14;
    localparam int MODE_W  = 3;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic [MODE_W-1:0] MODE_Q0   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_Q1   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_Q2   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_Q3   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FULL = 3'd4;

    // one walk step handed from the walk unit to the pixel emitter
    typedef struct packed {
        logic signed [WALK_W-1:0] wx;
        logic signed [WALK_W-1:0] wy;
        logic [MODE_W-1:0]        mode;
        logic                     fin;
        logic signed [PIX_W-1:0]  cx;
        logic signed [PIX_W-1:0]  cy;
    } crq_step_t;

endpackage

// ===== rtl/crq_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crq_walk
// walk state and error-term update, one position per accepted step while busy
// ----------------------------------------------------------------------------
module crq_walk
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic                                action,
    input  logic signed [crq_pkg::PIX_W-1:0]    center_x,
    input  logic signed [crq_pkg::PIX_W-1:0]    center_y,
    input  logic [crq_pkg::RAD_W-1:0]           radius,
    input  logic [crq_pkg::MODE_W-1:0]          mode,
    output logic                                load,
    output crq_pkg::crq_step_t                  step
);

    logic signed [crq_pkg::WALK_W-1:0] walk_x_reg, walk_x_next;
    logic signed [crq_pkg::WALK_W-1:0] walk_y_reg, walk_y_next;
    logic signed [crq_pkg::ERR_W-1:0]  err_reg, err_next;
    logic                              busy_reg, busy_next;
    logic [crq_pkg::MODE_W-1:0]        mode_reg, mode_next;
    logic signed [crq_pkg::PIX_W-1:0]  cx_reg, cx_next;
    logic signed [crq_pkg::PIX_W-1:0]  cy_reg, cy_next;

    logic signed [crq_pkg::ERR_W-1:0]  wx_e, wy_e, y1, e1, x1, e2;
    logic                              inc_y, inc_x, fin;

    always_comb
    begin
        wx_e  = crq_pkg::ERR_W'(walk_x_reg);
        wy_e  = crq_pkg::ERR_W'(walk_y_reg);
        inc_y = (err_reg <= wy_e);
        y1    = inc_y ? wy_e + 18'sd1 : wy_e;
        e1    = inc_y ? err_reg + (y1 <<< 1) + 18'sd1 : err_reg;
        inc_x = (err_reg > wx_e) || (e1 > y1);
        x1    = inc_x ? wx_e + 18'sd1 : wx_e;
        e2    = inc_x ? e1 + (x1 <<< 1) + 18'sd1 : e1;
        fin   = !x1[crq_pkg::ERR_W-1];
    end

    always_comb
    begin
        walk_x_next = walk_x_reg;
        walk_y_next = walk_y_reg;
        err_next    = err_reg;
        busy_next   = busy_reg;
        mode_next   = mode_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        load        = 1'b0;
        if (accept)
        begin
            if (action == crq_pkg::ACT_START)
            begin
                // unknown modes leave everything as it was
                if (mode <= crq_pkg::MODE_FULL)
                begin
                    mode_next   = mode;
                    cx_next     = center_x;
                    cy_next     = center_y;
                    walk_x_next = -$signed({2'b00, radius});
                    walk_y_next = '0;
                    err_next    = 18'sd2 - $signed({3'b000, radius, 1'b0});
                    busy_next   = 1'b1;
                end
            end
            else if (busy_reg)
            begin
                load        = 1'b1;
                walk_x_next = x1[crq_pkg::WALK_W-1:0];
                walk_y_next = y1[crq_pkg::WALK_W-1:0];
                err_next    = e2;
                busy_next   = !fin;
            end
        end
    end

    always_comb
    begin
        step.wx   = walk_x_reg;
        step.wy   = walk_y_reg;
        step.mode = mode_reg;
        step.fin  = fin;
        step.cx   = cx_reg;
        step.cy   = cy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_x_reg <= '0;
            walk_y_reg <= '0;
            err_reg    <= '0;
            busy_reg   <= 1'b0;
            mode_reg   <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
        end
        else
        begin
            walk_x_reg <= walk_x_next;
            walk_y_reg <= walk_y_next;
            err_reg    <= err_next;
            busy_reg   <= busy_next;
            mode_reg   <= mode_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
        end
    end

endmodule

// ===== rtl/crq_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crq_emit
// holds one walk step; mirrored pixels go one item per cycle while out_ready=1
// ----------------------------------------------------------------------------
module crq_emit
#(
    parameter int COORD_WIDTH = crq_pkg::COORD_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  crq_pkg::crq_step_t                  step,
    output logic                                free,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [crq_pkg::PIX_W-1:0]    pixel_x,
    output logic signed [crq_pkg::PIX_W-1:0]    pixel_y,
    output logic                                last
);

    crq_pkg::crq_step_t            rec_reg;
    logic                          valid_reg, valid_next;
    logic [1:0]                    idx_reg, idx_next;

    logic                          full, final_pix, done;
    logic [crq_pkg::MODE_W-1:0]    sel;
    logic signed [crq_pkg::WALK_W-1:0] dx, dy;
    logic signed [COORD_WIDTH-1:0] sum_x, sum_y;

    always_comb
    begin
        full      = (rec_reg.mode == crq_pkg::MODE_FULL);
        final_pix = !full || (idx_reg == 2'd3);
        done      = valid_reg && out_ready && final_pix;
        free      = !valid_reg || done;
        sel       = full ? {1'b0, idx_reg} : rec_reg.mode;
        case (sel)
            crq_pkg::MODE_Q0: begin dx = -rec_reg.wx; dy =  rec_reg.wy; end
            crq_pkg::MODE_Q1: begin dx = -rec_reg.wy; dy = -rec_reg.wx; end
            crq_pkg::MODE_Q2: begin dx =  rec_reg.wx; dy = -rec_reg.wy; end
            default:          begin dx =  rec_reg.wy; dy =  rec_reg.wx; end
        endcase
        // wrap at the coordinate width, then sign-extend to the port width
        sum_x   = COORD_WIDTH'(rec_reg.cx) + COORD_WIDTH'(dx);
        sum_y   = COORD_WIDTH'(rec_reg.cy) + COORD_WIDTH'(dy);
        pixel_x = crq_pkg::PIX_W'(sum_x);
        pixel_y = crq_pkg::PIX_W'(sum_y);
        last    = rec_reg.fin && final_pix;
        out_valid = valid_reg;
    end

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (done)
            valid_next = 1'b0;
        else if (valid_reg && out_ready)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rec_reg <= step;
    end

endmodule

// ===== rtl/circle_quadrant_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_quadrant_rasterizer
// latency: a step item's first pixel is offered the cycle after it is taken
// throughput: the pixel register sends one pixel per cycle while out_ready=1;
//   so quadrant modes take one item per cycle, full-circle on the last pixel
// reset: asynchronous, active low; walk idle, held centre and mode zero
// ----------------------------------------------------------------------------
module circle_quadrant_rasterizer
#(
    parameter int COORD_WIDTH = crq_pkg::COORD_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic signed [crq_pkg::PIX_W-1:0]    center_x,
    input  logic signed [crq_pkg::PIX_W-1:0]    center_y,
    input  logic [crq_pkg::RAD_W-1:0]           radius,
    input  logic [crq_pkg::MODE_W-1:0]          mode,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [crq_pkg::PIX_W-1:0]    pixel_x,
    output logic signed [crq_pkg::PIX_W-1:0]    pixel_y,
    output logic                                last
);

    // the walk unit advances on the cycle an item is taken; a step that
    // yields pixels is copied whole (centre included) into the emitter, so a
    // new start may be taken while the final older pixel is still being sent
    logic               accept;
    logic               load;
    logic               free;
    crq_pkg::crq_step_t step;

    // taken when the emitter is empty or is sending its final pixel now
    assign in_ready = free;
    assign accept   = in_valid && in_ready;

    crq_walk u_walk
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .action   (action),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .mode     (mode),
        .load     (load),
        .step     (step)
    );

    // mirrors, adds the centre and wraps at the coordinate width
    crq_emit #(.COORD_WIDTH(COORD_WIDTH)) u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .step      (step),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last      (last)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the circle quadrant rasterizer: items are queued by
// an initial block, sent by a clocked driver and predicted on acceptance; a
// clocked monitor checks every pixel in order against the predicted pixels
// ----------------------------------------------------------------------------
module tb;

    // timing and run limits
    localparam int TIMEOUT_NS  = 2_000_000;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_SHOWN   = 10;
    localparam int PHASE_ITEMS = 40;

    // codes the package does not name
    localparam logic [crq_pkg::MODE_W-1:0] MODE_FIRST_BAD = crq_pkg::MODE_FULL + 3'd1;
    localparam logic [crq_pkg::MODE_W-1:0] MODE_TOP       = '1;
    localparam logic [crq_pkg::RAD_W-1:0]  RAD_MAX        = '1;

    // one input item as the block sees it
    typedef struct {
        logic                              action;
        logic signed [crq_pkg::PIX_W-1:0]  cx;
        logic signed [crq_pkg::PIX_W-1:0]  cy;
        logic [crq_pkg::RAD_W-1:0]         radius;
        logic [crq_pkg::MODE_W-1:0]        mode;
    } raster_item_t;

    // one pixel result
    typedef struct {
        logic signed [crq_pkg::PIX_W-1:0]  px;
        logic signed [crq_pkg::PIX_W-1:0]  py;
        logic                              fin;
    } pixel_t;

    // walk position, error term and what the last start loaded
    typedef struct {
        logic signed [crq_pkg::WALK_W-1:0] wx;
        logic signed [crq_pkg::WALK_W-1:0] wy;
        logic signed [crq_pkg::ERR_W-1:0]  err;
        logic                              busy;
        logic [crq_pkg::MODE_W-1:0]        mode;
        logic signed [crq_pkg::PIX_W-1:0]  cx;
        logic signed [crq_pkg::PIX_W-1:0]  cy;
    } walk_state_t;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                action    = crq_pkg::ACT_START;
    logic signed [crq_pkg::PIX_W-1:0]    center_x  = '0;
    logic signed [crq_pkg::PIX_W-1:0]    center_y  = '0;
    logic [crq_pkg::RAD_W-1:0]           radius    = '0;
    logic [crq_pkg::MODE_W-1:0]          mode      = crq_pkg::MODE_Q0;
    logic                                out_ready = 1'b0;
    logic                                in_ready;
    logic                                out_valid;
    logic signed [crq_pkg::PIX_W-1:0]    pixel_x;
    logic signed [crq_pkg::PIX_W-1:0]    pixel_y;
    logic                                last;

    raster_item_t pending_items [$];    // items waiting for the driver
    pixel_t       pixels_due [$];       // predicted pixels, oldest first
    walk_state_t  model_walk;           // prediction state, advanced on acceptance
    walk_state_t  plan_walk;            // same walk, advanced as items are queued
    int           fail_count     = 0;
    int           items_made     = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;

    circle_quadrant_rasterizer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last      (last)
    );

    always #4 clk = ~clk;

    // centre plus offset, wrapping at the coordinate width
    function automatic pixel_t place(walk_state_t st, int dx, int dy, logic fin);
        pixel_t p;
        int     sx;
        int     sy;
        sx = int'(st.cx) + dx;
        sy = int'(st.cy) + dy;
        p.px = sx[crq_pkg::PIX_W-1:0];
        p.py = sy[crq_pkg::PIX_W-1:0];
        p.fin = fin;
        return p;
    endfunction

    // applies one item to a walk state, returns how many pixels it gives
    function automatic int rasterize(inout walk_state_t st, input raster_item_t it,
                                     output pixel_t pix [4]);
        int   x;
        int   y;
        int   e;
        int   prev;
        int   wx;
        int   wy;
        int   n;
        logic fin;
        n = 0;
        if (it.action == crq_pkg::ACT_START) begin
            // modes above full circle leave everything as it was
            if (it.mode > crq_pkg::MODE_FULL)
                return 0;
            x = -int'(it.radius);
            e = 2 + 2 * x;
            st.mode = it.mode;
            st.cx   = it.cx;
            st.cy   = it.cy;
            st.wx   = x[crq_pkg::WALK_W-1:0];
            st.wy   = '0;
            st.err  = e[crq_pkg::ERR_W-1:0];
            st.busy = 1'b1;
            return 0;
        end
        if (!st.busy)
            return 0;
        wx = int'(st.wx);
        wy = int'(st.wy);
        e  = int'(st.err);
        x = wx;
        y = wy;
        prev = e;
        // step the walk first so the final position can be flagged
        if (prev <= y) begin
            y = y + 1;
            e = e + 2 * y + 1;
        end
        if (prev > x || e > y) begin
            x = x + 1;
            e = e + 2 * x + 1;
        end
        fin = (x >= 0);
        case (st.mode)
            crq_pkg::MODE_Q0: begin pix[0] = place(st, -wx, wy, fin);  n = 1; end
            crq_pkg::MODE_Q1: begin pix[0] = place(st, -wy, -wx, fin); n = 1; end
            crq_pkg::MODE_Q2: begin pix[0] = place(st, wx, -wy, fin);  n = 1; end
            crq_pkg::MODE_Q3: begin pix[0] = place(st, wy, wx, fin);   n = 1; end
            default: begin
                pix[0] = place(st, -wx, wy, 1'b0);
                pix[1] = place(st, -wy, -wx, 1'b0);
                pix[2] = place(st, wx, -wy, 1'b0);
                pix[3] = place(st, wy, wx, fin);
                n = 4;
            end
        endcase
        st.wx  = x[crq_pkg::WALK_W-1:0];
        st.wy  = y[crq_pkg::WALK_W-1:0];
        st.err = e[crq_pkg::ERR_W-1:0];
        if (fin)
            st.busy = 1'b0;
        return n;
    endfunction

    // random coordinate, often close to either end so that offsets wrap
    function automatic logic signed [crq_pkg::PIX_W-1:0] rand_coord();
        logic [crq_pkg::PIX_W-1:0] v;
        v = crq_pkg::PIX_W'($urandom);
        if ($urandom_range(0, 9) < 3)
            v = v[crq_pkg::PIX_W-1] ? 16'h8000 + crq_pkg::PIX_W'($urandom_range(0, 40))
                                    : 16'h7FFF - crq_pkg::PIX_W'($urandom_range(0, 40));
        return v;
    endfunction

    task automatic add_item(raster_item_t it);
        pixel_t scratch [4];
        pending_items.push_back(it);
        void'(rasterize(plan_walk, it, scratch));
        items_made++;
    endtask

    task automatic add_start(logic signed [crq_pkg::PIX_W-1:0] cx,
                             logic signed [crq_pkg::PIX_W-1:0] cy,
                             logic [crq_pkg::RAD_W-1:0] r,
                             logic [crq_pkg::MODE_W-1:0] m);
        raster_item_t it;
        it.action = crq_pkg::ACT_START;
        it.cx     = cx;
        it.cy     = cy;
        it.radius = r;
        it.mode   = m;
        add_item(it);
    endtask

    // step item; the other fields carry noise the block must ignore
    task automatic add_step();
        raster_item_t it;
        it.action = crq_pkg::ACT_STEP;
        it.cx     = rand_coord();
        it.cy     = rand_coord();
        it.radius = crq_pkg::RAD_W'($urandom);
        it.mode   = crq_pkg::MODE_W'($urandom);
        add_item(it);
    endtask

    // steps until the planned walk finishes or the limit is reached
    task automatic add_walk(int limit);
        int k;
        k = 0;
        while (plan_walk.busy && k < limit) begin
            add_step();
            k++;
        end
    endtask

    // nothing queued, nothing in flight and no pixel outstanding
    task automatic wait_quiet();
        while (pending_items.size() != 0 || in_valid || pixels_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic report_mismatch(string what);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("%0t ns: %s", $time, what);
    endtask

    // driver: predicts on acceptance, then offers the next item or idles
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        raster_item_t taken;
        raster_item_t nxt;
        pixel_t       pix [4];
        int           n;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action   <= crq_pkg::ACT_START;
            center_x <= '0;
            center_y <= '0;
            radius   <= '0;
            mode     <= crq_pkg::MODE_Q0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                taken.action = action;
                taken.cx     = center_x;
                taken.cy     = center_y;
                taken.radius = radius;
                taken.mode   = mode;
                n = rasterize(model_walk, taken, pix);
                for (int k = 0; k < n; k++)
                    pixels_due.push_back(pix[k]);
            end
            // a held item stays put until it is taken
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_items.pop_front();
                    in_valid <= 1'b1;
                    action   <= nxt.action;
                    center_x <= nxt.cx;
                    center_y <= nxt.cy;
                    radius   <= nxt.radius;
                    mode     <= nxt.mode;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted pixel, then draws a new ready
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        pixel_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pixels_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                                              pixel_x, pixel_y, last));
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (pixel_x !== want.px || pixel_y !== want.py || last !== want.fin)
                        report_mismatch($sformatf(
                            {"pixel mismatch: expected x=%0d y=%0d last=%0b, ",
                             "got x=%0d y=%0d last=%0b"},
                            want.px, want.py, want.fin, pixel_x, pixel_y, last));
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // stimulus: directed items, then four phases of random circles
    initial
    begin : stim_proc
        int                        send_plan [4];
        int                        recv_plan [4];
        int                        phase_start;
        int                        sel;
        logic [crq_pkg::RAD_W-1:0] r;
        logic                      big;
        send_plan = '{0, 55, 0, 30};
        recv_plan = '{0, 0, 55, 30};
        model_walk = '{default: '0};
        plan_walk  = '{default: '0};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // step with nothing to draw
        add_step();
        // radius zero at the field extremes
        add_start(16'sh7FFF, 16'sh8000, '0, crq_pkg::MODE_Q0);
        add_walk(8);
        add_step();
        // full circle of radius one straddling the wrap point
        add_start(16'sh8000, 16'sh7FFF, crq_pkg::RAD_W'(1), crq_pkg::MODE_FULL);
        add_walk(8);
        add_start('0, '0, crq_pkg::RAD_W'(2), crq_pkg::MODE_Q1);
        add_walk(8);
        // largest radius, abandoned by the next start
        add_start(16'sd100, -16'sd100, RAD_MAX, crq_pkg::MODE_Q2);
        add_walk(2);
        add_start(-16'sd5, 16'sd7, crq_pkg::RAD_W'(3), crq_pkg::MODE_Q3);
        add_step();
        // bad mode mid-walk must leave the walk running
        add_start(rand_coord(), rand_coord(), crq_pkg::RAD_W'(9), MODE_FIRST_BAD);
        add_walk(12);
        add_start(rand_coord(), rand_coord(), crq_pkg::RAD_W'(5), MODE_TOP);
        // hold off until the directed pixels are all back
        wait_quiet();

        for (int p = 0; p < 4; p++)
        begin
            @(negedge clk);
            send_idle_pct  = send_plan[p];
            recv_stall_pct = recv_plan[p];
            phase_start = items_made;
            while (items_made - phase_start < PHASE_ITEMS)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 80)
                begin
                    // well-formed circle, mostly small
                    sel = $urandom_range(0, 99);
                    big = 1'b0;
                    if (sel < 80)
                        r = crq_pkg::RAD_W'($urandom_range(0, 12));
                    else if (sel < 95)
                        r = crq_pkg::RAD_W'($urandom_range(13, 40));
                    else
                    begin
                        r = crq_pkg::RAD_W'($urandom);
                        big = 1'b1;
                    end
                    add_start(rand_coord(), rand_coord(), r,
                              crq_pkg::MODE_W'($urandom_range(crq_pkg::MODE_Q0,
                                                              crq_pkg::MODE_FULL)));
                    if (big)
                        add_walk($urandom_range(1, 6));
                    else if ($urandom_range(0, 99) < 15)
                        add_walk($urandom_range(0, 4));
                    else
                        add_walk(1000);
                end
                else if (sel < 90)
                begin
                    add_step();
                end
                else
                begin
                    // bad mode, random fields
                    add_start(rand_coord(), rand_coord(), crq_pkg::RAD_W'($urandom),
                              crq_pkg::MODE_W'($urandom_range(MODE_FIRST_BAD, MODE_TOP)));
                end
            end
            wait_quiet();
        end

        // let any stray pixel show up before the verdict
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
